/* hdl/msc_pkg.sv */
// Shared types, codes and constants of the motion swing and clash detector.
package msc_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int SWING_LOW_W = 14;
    localparam int GRAV_W      = 32;
    localparam int TIME_W      = 32;
    localparam int PHASE_W     = 2;

    localparam int LO_N_W = SWING_LOW_W + CFG_DATA_W;
    localparam int HI_N_W = 2 * CFG_DATA_W;
    localparam int LO2_W  = 2 * LO_N_W;
    localparam int HI2_W  = 2 * HI_N_W;

    localparam logic [PHASE_W-1:0] PH_IGNITION = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RETRACT  = 2'd2;

    localparam logic [CFG_DATA_W-1:0]  RST_GRAVITY_ALPHA = 16'd58982;
    localparam logic [CFG_DATA_W-1:0]  RST_NORM_DIVISOR  = 16'd1;
    localparam logic [SWING_LOW_W-1:0] RST_SWING_LOW     = 14'd960;
    localparam logic [CFG_DATA_W-1:0]  RST_SWING_HIGH    = 16'd16000;
    localparam logic [CFG_DATA_W-1:0]  RST_CLASH_HOLD    = 16'd200;
    localparam logic [CFG_DATA_W-1:0]  RST_LOCKUP_HOLD   = 16'd1000;
    localparam logic [CFG_DATA_W-1:0]  RST_SWING_HOLD    = 16'd300;
    localparam logic [CFG_DATA_W-1:0]  RST_BLAST_HOLD    = 16'd300;

    typedef enum logic [2:0] {
        FX_NONE   = 3'd0,
        FX_HUM    = 3'd1,
        FX_CLASH  = 3'd2,
        FX_LOCKUP = 3'd3,
        FX_SWING  = 3'd4,
        FX_BLAST  = 3'd5
    } t_effect;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRAVITY_ALPHA = 3'd0,
        REG_NORM_DIVISOR  = 3'd1,
        REG_SWING_LOW     = 3'd2,
        REG_SWING_HIGH    = 3'd3,
        REG_CLASH_HOLD    = 3'd4,
        REG_LOCKUP_HOLD   = 3'd5,
        REG_SWING_HOLD    = 3'd6,
        REG_BLAST_HOLD    = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_GRAV,
        S_RESID,
        S_SQUARE,
        S_DECIDE
    } t_state;

    typedef struct packed {
        logic [CFG_DATA_W-1:0]  gravity_alpha;
        logic [CFG_DATA_W-1:0]  norm_divisor;
        logic [SWING_LOW_W-1:0] swing_low;
        logic [CFG_DATA_W-1:0]  swing_high;
        logic [CFG_DATA_W-1:0]  clash_hold_ms;
        logic [CFG_DATA_W-1:0]  lockup_hold_ms;
        logic [CFG_DATA_W-1:0]  swing_hold_ms;
        logic [CFG_DATA_W-1:0]  blast_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic mult;
        logic grav;
        logic resid;
        logic square;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

/* hdl/msc_cfg.sv */
// Configuration register file of the motion swing and clash detector.
module msc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output msc_pkg::t_cfg                  o_cfg
);
    import msc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_alpha  <= RST_GRAVITY_ALPHA;
            r_cfg.norm_divisor   <= RST_NORM_DIVISOR;
            r_cfg.swing_low      <= RST_SWING_LOW;
            r_cfg.swing_high     <= RST_SWING_HIGH;
            r_cfg.clash_hold_ms  <= RST_CLASH_HOLD;
            r_cfg.lockup_hold_ms <= RST_LOCKUP_HOLD;
            r_cfg.swing_hold_ms  <= RST_SWING_HOLD;
            r_cfg.blast_hold_ms  <= RST_BLAST_HOLD;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_GRAVITY_ALPHA: r_cfg.gravity_alpha  <= i_cfg_wdata;
                REG_NORM_DIVISOR:  r_cfg.norm_divisor   <= i_cfg_wdata;
                REG_SWING_LOW:     r_cfg.swing_low      <= i_cfg_wdata[SWING_LOW_W-1:0];
                REG_SWING_HIGH:    r_cfg.swing_high     <= i_cfg_wdata;
                REG_CLASH_HOLD:    r_cfg.clash_hold_ms  <= i_cfg_wdata;
                REG_LOCKUP_HOLD:   r_cfg.lockup_hold_ms <= i_cfg_wdata;
                REG_SWING_HOLD:    r_cfg.swing_hold_ms  <= i_cfg_wdata;
                REG_BLAST_HOLD:    r_cfg.blast_hold_ms  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/msc_ctrl.sv */
// Step sequencer of the motion swing and clash detector.
module msc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output msc_pkg::t_cmd     o_cmd,
    input  msc_pkg::t_status  i_status
);
    import msc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_MULT;
                end
            end
            S_MULT:   n_state = S_GRAV;
            S_GRAV:   n_state = S_RESID;
            S_RESID:  n_state = S_SQUARE;
            S_SQUARE: n_state = S_DECIDE;
            S_DECIDE: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_MULT:   o_cmd.mult   = 1'b1;
            S_GRAV:   o_cmd.grav   = 1'b1;
            S_RESID:  o_cmd.resid  = 1'b1;
            S_SQUARE: o_cmd.square = 1'b1;
            S_DECIDE: o_cmd.decide = i_status.out_free;
            default: ;
        endcase
    end

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath step issued");

    a_request_reaches_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |-> ##5 (r_state == S_DECIDE))
        else $error("accepted request did not reach the decision step");

endmodule

/* hdl/msc_dp.sv */
// Datapath of the motion swing and clash detector: filter, residual, window, effects.
module msc_dp #(
    parameter int SAMPLE_BITS   = msc_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = msc_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  msc_pkg::t_cfg                   i_cfg,
    input  msc_pkg::t_cmd                   i_cmd,
    output msc_pkg::t_status                o_status,
    input  logic [msc_pkg::IN_TDATA_W-1:0]  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [msc_pkg::OUT_TDATA_W-1:0] o_out_data
);
    import msc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int FB    = FRACTION_BITS;
    localparam int PA_W  = GRAV_W + CFG_DATA_W + 1;
    localparam int PB_W  = SB + CFG_DATA_W + 2;
    localparam int ACC_W = ((PB_W + FB) > PA_W ? (PB_W + FB) : PA_W) + 1;
    localparam int D_W   = ((SB + FB) > GRAV_W ? (SB + FB) : GRAV_W) + 1;
    localparam int Q_W   = D_W - FB;
    localparam int SQ_W  = 2 * SB;
    localparam int RND_HALF = 32768;

    // request field positions
    localparam int AX_LSB  = 0;
    localparam int AY_LSB  = 16;
    localparam int AZ_LSB  = 32;
    localparam int MOT_BIT = 48;
    localparam int ON_BIT  = 49;
    localparam int PH_LSB  = 50;
    localparam int BL_BIT  = 52;
    localparam int LK_BIT  = 53;
    localparam int NOW_LSB = 54;

    logic signed [SB-1:0]     r_a [3];
    logic                     r_motion;
    logic                     r_on;
    logic [PHASE_W-1:0]       r_phase;
    logic                     r_blast_arm;
    logic                     r_lock_arm;
    logic [TIME_W-1:0]        r_now;

    logic signed [PA_W-1:0]   r_pa [3];
    logic signed [PA_W-1:0]   n_pa [3];
    logic signed [PB_W-1:0]   r_pb [3];
    logic signed [PB_W-1:0]   n_pb [3];
    logic signed [GRAV_W-1:0] r_grav [3];
    logic signed [GRAV_W-1:0] n_grav [3];
    logic signed [SB-1:0]     r_res [3];
    logic signed [SB-1:0]     n_res [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [SQ_W-1:0]          n_sq [3];

    logic [CFG_DATA_W-1:0]    w_div;
    logic [LO_N_W-1:0]        r_lo_n;
    logic [HI_N_W-1:0]        r_hi_n;
    logic [LO2_W-1:0]         r_lo2;
    logic [HI2_W-1:0]         r_hi2;
    logic [SQ_W-1:0]          w_sum;
    logic                     w_swing;
    logic [TIME_W-1:0]        w_elapsed;

    logic                     r_clash_pending;
    t_effect                  r_active;
    logic [TIME_W-1:0]        r_start;
    logic                     n_clash_pending;
    t_effect                  n_active;
    logic [TIME_W-1:0]        n_start;
    t_effect                  n_effect;
    logic                     n_dis_b;
    logic                     n_dis_l;

    logic                     r_out_valid;
    t_effect                  r_effect;
    logic                     r_dis_b;
    logic                     r_dis_l;

    assign w_div = (i_cfg.norm_divisor == '0) ? CFG_DATA_W'(1) : i_cfg.norm_divisor;

    always_comb begin : axis_math
        logic [CFG_DATA_W:0]     beta;
        logic signed [ACC_W-1:0] acc;
        logic signed [D_W-1:0]   d;
        logic signed [D_W-1:0]   bias;
        logic signed [D_W-1:0]   t;
        logic signed [Q_W-1:0]   q;
        logic signed [SQ_W-1:0]  p;
        beta = {1'b1, {CFG_DATA_W{1'b0}}} - {1'b0, i_cfg.gravity_alpha};
        for (int i = 0; i < 3; i++) begin
            n_pa[i] = $signed({1'b0, i_cfg.gravity_alpha}) * r_grav[i];
            n_pb[i] = $signed({1'b0, beta}) * r_a[i];

            // round half up, floor shift, saturate to the gravity range
            acc = ACC_W'(r_pa[i]) + (ACC_W'(r_pb[i]) <<< FB) + ACC_W'(RND_HALF);
            if ((&acc[ACC_W-1:GRAV_W+15]) || !(|acc[ACC_W-1:GRAV_W+15])) begin
                n_grav[i] = acc[GRAV_W+15:16];
            end else if (acc[ACC_W-1]) begin
                n_grav[i] = {1'b1, {(GRAV_W-1){1'b0}}};
            end else begin
                n_grav[i] = {1'b0, {(GRAV_W-1){1'b1}}};
            end

            // truncate toward zero: bias negative values before the shift
            d    = (D_W'(r_a[i]) <<< FB) - D_W'(r_grav[i]);
            bias = d[D_W-1] ? D_W'({FB{1'b1}}) : '0;
            t    = d + bias;
            q    = t[D_W-1:FB];
            if ((&q[Q_W-1:SB-1]) || !(|q[Q_W-1:SB-1])) begin
                n_res[i] = q[SB-1:0];
            end else if (q[Q_W-1]) begin
                n_res[i] = {1'b1, {(SB-1){1'b0}}};
            end else begin
                n_res[i] = {1'b0, {(SB-1){1'b1}}};
            end

            p       = r_res[i] * r_res[i];
            n_sq[i] = p;
        end
    end

    assign w_sum     = r_sq[0] + r_sq[1] + r_sq[2];
    assign w_swing   = (HI2_W'(w_sum) > HI2_W'(r_lo2)) && (HI2_W'(w_sum) < r_hi2);
    assign w_elapsed = r_now - r_start;

    always_comb begin : effect_logic
        logic clash;
        logic started_c;
        logic started_s;
        n_clash_pending = r_clash_pending;
        n_active        = r_active;
        n_start         = r_start;
        n_effect        = FX_NONE;
        n_dis_b         = 1'b0;
        n_dis_l         = 1'b0;
        started_c       = 1'b0;
        started_s       = 1'b0;
        clash           = 1'b0;
        if (r_phase == PH_IGNITION) begin
            n_clash_pending = 1'b0;
        end
        if (r_on && r_motion) begin
            n_clash_pending = 1'b1;
        end
        if (r_on && r_phase != PH_IGNITION && r_phase != PH_RETRACT) begin
            clash           = n_clash_pending;
            n_clash_pending = 1'b0;
            if (clash && n_active == FX_NONE) begin
                n_active  = r_lock_arm ? FX_LOCKUP : FX_CLASH;
                n_dis_l   = r_lock_arm;
                n_start   = r_now;
                n_effect  = n_active;
                started_c = 1'b1;
            end
            // an effect started this step has zero elapsed time and cannot expire
            if (!started_c &&
                ((n_active == FX_LOCKUP && w_elapsed > TIME_W'(i_cfg.lockup_hold_ms)) ||
                 (n_active == FX_CLASH  && w_elapsed > TIME_W'(i_cfg.clash_hold_ms)))) begin
                n_active = FX_NONE;
                n_effect = FX_HUM;
            end
            if (w_swing && n_active == FX_NONE) begin
                n_active  = r_blast_arm ? FX_BLAST : FX_SWING;
                n_dis_b   = r_blast_arm;
                n_start   = r_now;
                n_effect  = n_active;
                started_s = 1'b1;
            end
            if (!started_s &&
                ((n_active == FX_BLAST && w_elapsed > TIME_W'(i_cfg.blast_hold_ms)) ||
                 (n_active == FX_SWING && w_elapsed > TIME_W'(i_cfg.swing_hold_ms)))) begin
                n_active = FX_NONE;
                n_effect = FX_HUM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_a[0]      <= i_in_data[AX_LSB+SB-1:AX_LSB];
            r_a[1]      <= i_in_data[AY_LSB+SB-1:AY_LSB];
            r_a[2]      <= i_in_data[AZ_LSB+SB-1:AZ_LSB];
            r_motion    <= i_in_data[MOT_BIT];
            r_on        <= i_in_data[ON_BIT];
            r_phase     <= i_in_data[PH_LSB+PHASE_W-1:PH_LSB];
            r_blast_arm <= i_in_data[BL_BIT];
            r_lock_arm  <= i_in_data[LK_BIT];
            r_now       <= i_in_data[NOW_LSB+TIME_W-1:NOW_LSB];
        end
        if (i_cmd.mult) begin
            for (int i = 0; i < 3; i++) begin
                r_pa[i] <= n_pa[i];
                r_pb[i] <= n_pb[i];
            end
            r_lo_n <= i_cfg.swing_low * w_div;
            r_hi_n <= i_cfg.swing_high * w_div;
        end
        if (i_cmd.grav) begin
            r_lo2 <= r_lo_n * r_lo_n;
            r_hi2 <= r_hi_n * r_hi_n;
        end
        if (i_cmd.resid) begin
            for (int i = 0; i < 3; i++) begin
                r_res[i] <= n_res[i];
            end
        end
        if (i_cmd.square) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= n_sq[i];
            end
        end
        if (i_cmd.decide) begin
            r_effect <= n_effect;
            r_dis_b  <= n_dis_b;
            r_dis_l  <= n_dis_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_grav[i] <= '0;
            end
        end else if (i_cmd.grav) begin
            for (int i = 0; i < 3; i++) begin
                r_grav[i] <= n_grav[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clash_pending <= 1'b0;
            r_active        <= FX_NONE;
            r_start         <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_clash_pending <= n_clash_pending;
                r_active        <= n_active;
                r_start         <= n_start;
            end
            if (i_cmd.decide) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = {{(OUT_TDATA_W-5){1'b0}}, r_dis_l, r_dis_b, r_effect};

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |-> (!r_out_valid || i_out_ready))
        else $error("result written over one not yet taken");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> r_out_valid)
        else $error("decision step left no result");

    a_lockup_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dis_l) |-> (r_effect == FX_LOCKUP))
        else $error("lockup request consumed without lockup effect");

    a_blast_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dis_b) |-> (r_effect == FX_BLAST))
        else $error("blaster request consumed without blaster effect");

endmodule

/* hdl/motion_swing_clash_detector_core.sv */
// Top level of the motion swing and clash detector.
//
// One accelerometer request gives exactly one result. A request is taken in the idle
// cycle and then passes five datapath steps (products, gravity update, residual,
// squares, window and effect decision), so the block takes a new request only once
// the last one has left the decision step; the step sequencer and its single
// datapath set this. The result sits in an output register, so the next request is
// taken while a result waits; the decision step holds only while an earlier result is
// still untaken. Configuration writes take effect on the next clock edge.
module motion_swing_clash_detector_core #(
    parameter int SAMPLE_BITS   = msc_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = msc_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], motion_flag[48], blade_on[49],
    // phase[51:50], blaster_armed[52], lockup_armed[53], now_ms[85:54], zero[87:86]
    input  logic [msc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // effect[2:0], disarm_blaster[3], disarm_lockup[4], zero[7:5]
    output logic [msc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                            i_cfg_we,
    input  logic [msc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [msc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import msc_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    msc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    msc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_status   (w_status)
    );

    msc_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

/* tb/motion_swing_clash_detector_core_test.sv */
// Self-checking testbench of the motion swing and clash detector core.
`timescale 1ns / 100ps

module motion_swing_clash_detector_core_test;
    import msc_pkg::*;

    localparam logic [PHASE_W-1:0] PH_STEADY = 2'd0;
    localparam logic [PHASE_W-1:0] PH_SPARE  = 2'd3;
    localparam int HOLD_OFF_CYCLES = 400;

    typedef struct {
        logic signed [15:0]   ax;
        logic signed [15:0]   ay;
        logic signed [15:0]   az;
        logic                 motion;
        logic                 on;
        logic [PHASE_W-1:0]   ph;
        logic                 blast_arm;
        logic                 lock_arm;
        logic [TIME_W-1:0]    now;
    } t_sample;

    // Same bit order as the result bus: effect lowest, then the disarm flags.
    typedef struct packed {
        logic    disarm_lockup;
        logic    disarm_blaster;
        t_effect fx;
    } t_fx_out;

    typedef struct {
        t_sample s;
        logic    typed;
        t_fx_out r;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata;

    motion_swing_clash_detector_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Register copy and detector state of the predictor
    logic [CFG_DATA_W-1:0]  cfg_alpha;
    logic [CFG_DATA_W-1:0]  cfg_div;
    logic [SWING_LOW_W-1:0] cfg_swing_low;
    logic [CFG_DATA_W-1:0]  cfg_swing_high;
    logic [CFG_DATA_W-1:0]  cfg_clash_hold;
    logic [CFG_DATA_W-1:0]  cfg_lockup_hold;
    logic [CFG_DATA_W-1:0]  cfg_swing_hold;
    logic [CFG_DATA_W-1:0]  cfg_blast_hold;

    logic signed [GRAV_W-1:0] grav_x, grav_y, grav_z;
    logic                     clash_latch;
    t_effect                  active_fx;
    logic [TIME_W-1:0]        fx_start;

    t_fx_out     effects_due[$];
    t_row        directed_rows[$];
    logic [31:0] sim_ms;
    int          gap_pct;
    int          stall_pct;
    logic        rx_hold_req;
    int          n_errors = 0;
    int          n_sent;
    int          n_checked = 0;
    int          n_backpressure;
    int          fx_seen[6] = '{default: 0};

    function automatic logic signed [GRAV_W-1:0] gravity_next(logic signed [GRAV_W-1:0] g,
                                                              logic signed [15:0] a);
        longint acc;
        longint q;
        acc = longint'(cfg_alpha) * longint'(g)
            + (64'sd65536 - longint'(cfg_alpha)) * (longint'(a) * 64'sd65536)
            + 64'sd32768;
        q = acc >>> 16;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q[31:0];
    endfunction

    function automatic longint residual_of(logic signed [15:0] a, logic signed [GRAV_W-1:0] g);
        longint d;
        longint q;
        d = longint'(a) * 64'sd65536 - longint'(g);
        if (d >= 0) begin
            q = d >>> 16;
        end else begin
            q = -((-d) >>> 16);
        end
        if (q > 64'sd32767) q = 64'sd32767;
        if (q < -64'sd32768) q = -64'sd32768;
        return q;
    endfunction

    function automatic logic held_past(logic [TIME_W-1:0] now, logic [CFG_DATA_W-1:0] hold);
        logic [TIME_W-1:0] dt;
        dt = now - fx_start;
        return dt > {16'd0, hold};
    endfunction

    // Advance the detector by one sample and return the effect change it makes.
    function automatic t_fx_out next_effect(t_sample s);
        longint      rx, ry, rz;
        logic [63:0] mag2, n, lo, hi;
        logic        clash, swing;
        t_fx_out     r;
        r = '0;
        r.fx = FX_NONE;
        if (s.ph == PH_IGNITION) clash_latch = 1'b0;
        grav_x = gravity_next(grav_x, s.ax);
        grav_y = gravity_next(grav_y, s.ay);
        grav_z = gravity_next(grav_z, s.az);
        rx = residual_of(s.ax, grav_x);
        ry = residual_of(s.ay, grav_y);
        rz = residual_of(s.az, grav_z);
        mag2 = rx * rx + ry * ry + rz * rz;
        if (s.on) begin
            if (s.motion) clash_latch = 1'b1;
            if (s.ph != PH_IGNITION && s.ph != PH_RETRACT) begin
                clash = clash_latch;
                clash_latch = 1'b0;
                if (clash && active_fx == FX_NONE) begin
                    if (s.lock_arm) begin
                        r.disarm_lockup = 1'b1;
                        active_fx = FX_LOCKUP;
                    end else begin
                        active_fx = FX_CLASH;
                    end
                    fx_start = s.now;
                    r.fx = active_fx;
                end
                if ((active_fx == FX_LOCKUP && held_past(s.now, cfg_lockup_hold)) ||
                    (active_fx == FX_CLASH && held_past(s.now, cfg_clash_hold))) begin
                    active_fx = FX_NONE;
                    r.fx = FX_HUM;
                end
                // Compare squares so no root is needed; a zero divisor acts as one.
                n = (cfg_div == 0) ? 64'd1 : 64'(cfg_div);
                lo = 64'(cfg_swing_low) * n;
                hi = 64'(cfg_swing_high) * n;
                swing = (mag2 > lo * lo) && (mag2 < hi * hi);
                if (swing && active_fx == FX_NONE) begin
                    if (s.blast_arm) begin
                        r.disarm_blaster = 1'b1;
                        active_fx = FX_BLAST;
                    end else begin
                        active_fx = FX_SWING;
                    end
                    fx_start = s.now;
                    r.fx = active_fx;
                end
                if ((active_fx == FX_BLAST && held_past(s.now, cfg_blast_hold)) ||
                    (active_fx == FX_SWING && held_past(s.now, cfg_swing_hold))) begin
                    active_fx = FX_NONE;
                    r.fx = FX_HUM;
                end
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] jolt(int base);
        int v;
        if ($urandom_range(0, 99) < 25) begin
            v = base + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1000, 20000));
        end else begin
            v = base + int'($urandom_range(0, 600)) - 300;
        end
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Mostly steady blade-on motion with a running clock; the rest is raw noise.
    function automatic t_sample random_sample();
        t_sample s;
        int      k;
        if ($urandom_range(0, 99) < 15) begin
            s.ax = 16'($urandom);
            s.ay = 16'($urandom);
            s.az = 16'($urandom);
            s.motion = 1'($urandom_range(0, 1));
            s.on = 1'($urandom_range(0, 1));
            s.ph = PHASE_W'($urandom_range(0, 3));
            s.blast_arm = 1'($urandom_range(0, 1));
            s.lock_arm = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 3) == 0) begin
                s.now = $urandom;
            end else begin
                s.now = sim_ms + $urandom_range(0, 2000);
            end
            sim_ms = s.now;
        end else begin
            k = $urandom_range(0, 99);
            s.on = 1'b1;
            s.ph = (k < 88) ? PH_STEADY : (k < 94) ? PH_IGNITION : PH_RETRACT;
            s.motion = ($urandom_range(0, 99) < 12);
            s.blast_arm = ($urandom_range(0, 99) < 35);
            s.lock_arm = ($urandom_range(0, 99) < 35);
            sim_ms = sim_ms + $urandom_range(0, 350);
            s.now = sim_ms;
            s.ax = jolt(0);
            s.ay = jolt(0);
            s.az = jolt(16384);
        end
        return s;
    endfunction

    function automatic void add_row(int ax, int ay, int az, logic motion, logic on,
                                    logic [PHASE_W-1:0] ph, logic ba, logic la,
                                    logic [31:0] now, logic typed, t_effect fx,
                                    logic db, logic dl);
        t_row row;
        row.s.ax = ax[15:0];
        row.s.ay = ay[15:0];
        row.s.az = az[15:0];
        row.s.motion = motion;
        row.s.on = on;
        row.s.ph = ph;
        row.s.blast_arm = ba;
        row.s.lock_arm = la;
        row.s.now = now;
        row.typed = typed;
        row.r.fx = fx;
        row.r.disarm_blaster = db;
        row.r.disarm_lockup = dl;
        directed_rows.push_back(row);
    endfunction

    // Offer one request and log its expected result once it is taken.
    task automatic offer(t_sample s, logic typed, t_fx_out typed_r);
        t_fx_out r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {2'b00, s.now, s.lock_arm, s.blast_arm, s.ph, s.on, s.motion,
                        s.az, s.ay, s.ax};
        do begin
            @(posedge i_clk);
            if (!s_axis_tready) n_backpressure++;
        end while (!s_axis_tready);
        r = next_effect(s);
        effects_due.push_back(typed ? typed_r : r);
        n_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (effects_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_GRAVITY_ALPHA: cfg_alpha = val;
            REG_NORM_DIVISOR:  cfg_div = val;
            REG_SWING_LOW:     cfg_swing_low = val[SWING_LOW_W-1:0];
            REG_SWING_HIGH:    cfg_swing_high = val;
            REG_CLASH_HOLD:    cfg_clash_hold = val;
            REG_LOCKUP_HOLD:   cfg_lockup_hold = val;
            REG_SWING_HOLD:    cfg_swing_hold = val;
            REG_BLAST_HOLD:    cfg_blast_hold = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(int alpha, int div, int slo, int shi,
                            int ch, int lh, int sh, int bh);
        write_reg(REG_GRAVITY_ALPHA, alpha[15:0]);
        write_reg(REG_NORM_DIVISOR, div[15:0]);
        write_reg(REG_SWING_LOW, slo[15:0]);
        write_reg(REG_SWING_HIGH, shi[15:0]);
        write_reg(REG_CLASH_HOLD, ch[15:0]);
        write_reg(REG_LOCKUP_HOLD, lh[15:0]);
        write_reg(REG_SWING_HOLD, sh[15:0]);
        write_reg(REG_BLAST_HOLD, bh[15:0]);
    endtask

    task automatic run_random(int count, logic mixed, logic pressure);
        int k;
        for (int i = 0; i < count; i++) begin
            if (mixed && i % 30 == 0) begin
                k = $urandom_range(0, 3);
                gap_pct = (k == 1) ? 71 : (k == 3) ? 38 : 0;
                stall_pct = (k == 2) ? 71 : (k == 3) ? 38 : 0;
            end
            // Hold the result side off while requests keep coming, later drain fully.
            if (pressure && i == 40) rx_hold_req = 1'b1;
            if (pressure && i == 120) drain_results();
            offer(random_sample(), 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** motion_swing_clash_detector_core: FAILED **");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int   hold_left;
        logic hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_fx_out got;
        t_fx_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_fx_out'(m_axis_tdata[4:0]);
            if (effects_due.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual 0x%0h",
                         $time, m_axis_tdata);
            end else begin
                want = effects_due.pop_front();
                n_checked++;
                if (got.fx !== want.fx) begin
                    n_errors++;
                    $display("%0t: effect mismatch, expected %0d, actual %0d",
                             $time, want.fx, got.fx);
                end
                if (got.disarm_blaster !== want.disarm_blaster) begin
                    n_errors++;
                    $display("%0t: disarm_blaster mismatch, expected %0b, actual %0b",
                             $time, want.disarm_blaster, got.disarm_blaster);
                end
                if (got.disarm_lockup !== want.disarm_lockup) begin
                    n_errors++;
                    $display("%0t: disarm_lockup mismatch, expected %0b, actual %0b",
                             $time, want.disarm_lockup, got.disarm_lockup);
                end
                if (got.fx <= FX_BLAST) fx_seen[got.fx]++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        rx_hold_req = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        n_sent = 0;
        n_backpressure = 0;
        cfg_alpha = RST_GRAVITY_ALPHA;
        cfg_div = RST_NORM_DIVISOR;
        cfg_swing_low = RST_SWING_LOW;
        cfg_swing_high = RST_SWING_HIGH;
        cfg_clash_hold = RST_CLASH_HOLD;
        cfg_lockup_hold = RST_LOCKUP_HOLD;
        cfg_swing_hold = RST_SWING_HOLD;
        cfg_blast_hold = RST_BLAST_HOLD;
        grav_x = '0;
        grav_y = '0;
        grav_z = '0;
        clash_latch = 1'b0;
        active_fx = FX_NONE;
        fx_start = '0;

        // Blade off and non-steady phases: no effect at all
        add_row(32767, 32767, 32767, 1, 0, PH_STEADY, 1, 1, 0, 1, FX_NONE, 0, 0);
        add_row(-32768, -32768, -32768, 1, 0, PH_STEADY, 0, 0, 32'hFFFF_FFFF,
                1, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 1, 1, PH_IGNITION, 0, 0, 100, 1, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_RETRACT, 0, 0, 200, 1, FX_NONE, 0, 0);
        // Clash latched during ignition turns into a lockup once steady
        add_row(0, 0, 16384, 0, 1, PH_STEADY, 0, 1, 1000, 1, FX_LOCKUP, 0, 1);
        add_row(0, 0, 16384, 1, 1, PH_STEADY, 0, 1, 1500, 0, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_STEADY, 0, 0, 2001, 0, FX_NONE, 0, 0);
        add_row(20000, -20000, 16384, 0, 1, PH_STEADY, 1, 0, 2100, 0, FX_NONE, 0, 0);
        add_row(20000, -20000, 16384, 0, 1, PH_STEADY, 1, 0, 2500, 0, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 1, 1, PH_SPARE, 0, 0, 3000, 0, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_SPARE, 0, 0, 3300, 0, FX_NONE, 0, 0);
        // Ignition drops a clash latched during retraction
        add_row(0, 0, 16384, 1, 1, PH_RETRACT, 0, 0, 4000, 1, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_IGNITION, 0, 0, 4001, 1, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_STEADY, 0, 0, 4002, 0, FX_NONE, 0, 0);
        // Timer wraps around zero
        add_row(0, 0, 16384, 1, 1, PH_STEADY, 0, 0, 32'hFFFF_FF00, 0, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_STEADY, 0, 0, 32'h0000_0100, 0, FX_NONE, 0, 0);
        // Motion with blade off is not latched
        add_row(0, 0, 16384, 1, 0, PH_STEADY, 0, 0, 5000, 1, FX_NONE, 0, 0);
        add_row(0, 0, 16384, 0, 1, PH_STEADY, 0, 0, 5001, 0, FX_NONE, 0, 0);
        // Full-scale samples saturate the residual
        add_row(-32768, -32768, -32768, 0, 1, PH_STEADY, 1, 0, 6000, 0, FX_NONE, 0, 0);
        add_row(32767, 32767, 32767, 0, 1, PH_STEADY, 0, 0, 6001, 0, FX_NONE, 0, 0);
        add_row(32767, -32768, 0, 1, 1, PH_STEADY, 1, 1, 6400, 0, FX_NONE, 0, 0);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            offer(directed_rows[i].s, directed_rows[i].typed, directed_rows[i].r);
        end
        drain_results();

        for (int p = 1; p <= 6; p++) begin
            sim_ms = $urandom;
            case (p)
                1: begin
                    set_regs($urandom_range(0, 65535), $urandom_range(1, 3),
                             $urandom_range(300, 1500), $urandom_range(6000, 30000),
                             $urandom_range(20, 600), $urandom_range(20, 600),
                             $urandom_range(20, 600), $urandom_range(20, 600));
                    gap_pct = 0;
                    stall_pct = 0;
                end
                2: begin
                    set_regs(0, 0, 0, 65535, 0, 0, 0, 0);
                    gap_pct = 71;
                    stall_pct = 0;
                end
                3: begin
                    set_regs(65535, 65535, 16000, 65535, 65535, 65535, 65535, 65535);
                    gap_pct = 0;
                    stall_pct = 71;
                end
                4: begin
                    set_regs(32768, 2, 500, 8000, $urandom_range(100, 400),
                             $urandom_range(100, 400), $urandom_range(100, 400),
                             $urandom_range(100, 400));
                    gap_pct = 38;
                    stall_pct = 38;
                end
                5: begin
                    set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 16000), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535),
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                default: begin
                    set_regs(58982, 1, 960, 0, 200, 1000, 300, 300);
                end
            endcase
            run_random(180, p >= 5, p == 1);
            drain_results();
        end

        repeat (20) @(posedge i_clk);
        $display("Run: %0d samples over six register settings and all idle mixes, %0d checked.",
                 n_sent, n_checked);
        $display("Effects: hum %0d clash %0d lockup %0d swing %0d blaster %0d; stalled %0d.",
                 fx_seen[FX_HUM], fx_seen[FX_CLASH], fx_seen[FX_LOCKUP],
                 fx_seen[FX_SWING], fx_seen[FX_BLAST], n_backpressure);
        if (n_errors == 0) begin
            $display("** motion_swing_clash_detector_core: PASSED **");
        end else begin
            $display("** motion_swing_clash_detector_core: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/msc_pkg.sv
hdl/msc_cfg.sv
hdl/msc_ctrl.sv
hdl/msc_dp.sv
hdl/motion_swing_clash_detector_core.sv
tb/motion_swing_clash_detector_core_test.sv
